### rtl/mcpi_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mcpi_pkg - shared types and constants of the motor current PI controller
// Mode and operation codes, register indexes, sequencer states, the control
// bundle between sequencer and datapath, and the fixed datapath widths.
// ============================================================================
package mcpi_pkg;

    // Payload widths
    localparam int DUTY_W   = 16;
    localparam int REF_W    = 9;
    localparam int CUR_W    = 13;
    localparam int SAMPLE_W = 7;
    localparam int CMD_W    = 8;
    localparam int INTEG_W  = 24;
    localparam int DRIVE_W  = 16;
    localparam int CHG_W    = 18;
    localparam int ERR_W    = 14;
    localparam int MAG_W    = 15;

    // Shared multiplier and accumulator widths
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 44;

    // Drive limit: +/-100.00 percent in Q8.8
    localparam int DRIVE_FULL = 25600;
    localparam int PWM_LIMIT  = 100;

    // x / 100 as (x * RECIP_M) >> RECIP_SHIFT, exact for x below 2^23
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_IN_W  = 23;
    localparam logic [23:0] RECIP_M = 24'd10737419;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LOW  = 3'd5;

    // Operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_PWM  = 2'd1,
        MODE_TEST = 2'd2
    } mode_t;

    // Which work an accepted item needs
    typedef enum logic [1:0] {
        PATH_QUICK = 2'd0,
        PATH_PWM   = 2'd1,
        PATH_TEST  = 2'd2
    } path_t;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MS_NONE  = 3'd0,
        MS_P     = 3'd1,
        MS_I     = 3'd2,
        MS_D     = 3'd3,
        MS_DUTY  = 3'd4,
        MS_RECIP = 3'd5
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_ERR       = 4'd1,
        ST_MUL_P     = 4'd2,
        ST_MUL_I     = 4'd3,
        ST_MUL_D     = 4'd4,
        ST_SUM       = 4'd5,
        ST_MUL_DUTY  = 4'd6,
        ST_MUL_RECIP = 4'd7,
        ST_OUT       = 4'd8
    } state_t;

    // Strobes from the sequencer to the datapath
    typedef struct packed {
        logic     load;
        logic     err_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_add;
        logic     sum_step;
        logic     out_step;
    } ctl_t;

endpackage

### rtl/mcpi_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// mcpi_mul - shared signed multiplier
// One 25x25 signed multiply per cycle while en is high, with a registered product; all gain,
// duty and reciprocal products of the controller pass through it in turn.
// ============================================================================
module mcpi_mul
    import mcpi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Hold the product unless a new multiply is issued
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

### rtl/mcpi_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// mcpi_ctrl - sequencer of the current controller
// Steps test items through error, three gain products, drive update, duty
// product, reciprocal scaling; PWM items only the last two; then output.
// ============================================================================
module mcpi_ctrl
    import mcpi_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  path_t path,
    input  logic  out_free,
    output logic  s_ready,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (path)
                        PATH_TEST: state_next = ST_ERR;
                        PATH_PWM:  state_next = ST_MUL_DUTY;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_ERR:       state_next = ST_MUL_P;
            ST_MUL_P:     state_next = ST_MUL_I;
            ST_MUL_I:     state_next = ST_MUL_D;
            ST_MUL_D:     state_next = ST_SUM;
            ST_SUM:       state_next = ST_MUL_DUTY;
            ST_MUL_DUTY:  state_next = ST_MUL_RECIP;
            ST_MUL_RECIP: state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Decode strobes
    always_comb begin
        s_ready      = 1'b0;
        ctl          = '0;
        ctl.mul_sel  = MS_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
            end
            ST_ERR: begin
                ctl.err_step = 1'b1;
            end
            ST_MUL_P: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_P;
            end
            ST_MUL_I: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_I;
                ctl.acc_add = 1'b1;
            end
            ST_MUL_D: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_D;
                ctl.acc_add = 1'b1;
            end
            ST_SUM: begin
                ctl.sum_step = 1'b1;
            end
            ST_MUL_DUTY: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_DUTY;
            end
            ST_MUL_RECIP: begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MS_RECIP;
            end
            ST_OUT: begin
                ctl.out_step = 1'b1;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

endmodule

### rtl/motor_current_pi_controller_core.sv
`timescale 1ns / 1ps
// Flow: items are taken only while the sequencer is idle, so a new item is
//   accepted only after the last result is in the output register.
// A test tick runs five products in turn through the single 25x25 multiplier.
// Reset: aresetn (synchronous, active low) restores register defaults,
//   idle mode and a cleared controller; no clearing pass is needed.
// ============================================================================
// motor_current_pi_controller_core - motor current loop with PI control
// Idle, direct PWM and square-wave current test modes; the test mode runs a
// Q8.8 PI controller with integral clamp and a gain on the last drive change.
// ============================================================================
module motor_current_pi_controller_core
    import mcpi_pkg::*;
#(
    parameter int TEST_SAMPLES   = 100,
    parameter int SEGMENT_TICKS  = 25,
    parameter int STEP_AMPLITUDE = 200
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // Input items
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [1:0]               s_new_mode,
    input  logic signed [CMD_W-1:0]  s_duty_command,
    input  logic signed [CUR_W-1:0]  s_measured_current,
    // Result items
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DUTY_W-1:0]        m_duty_value,
    output logic                     m_direction,
    output logic signed [REF_W-1:0]  m_reference_current,
    output logic signed [CUR_W-1:0]  m_current_echo,
    output logic [SAMPLE_W-1:0]      m_sample_index,
    output logic                     m_sample_valid,
    output logic [1:0]               m_mode_now
);

    localparam int CNT_W = $clog2(TEST_SAMPLES + 1);
    localparam int SEG_W = (SEGMENT_TICKS > 1) ? $clog2(SEGMENT_TICKS) : 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TEST_SAMPLES);
    localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGMENT_TICKS - 1);
    localparam logic signed [ERR_W-1:0] AMP = ERR_W'(STEP_AMPLITUDE);
    localparam logic signed [ACC_W-1:0] ACC_POS = ACC_W'(DRIVE_FULL);
    localparam logic signed [ACC_W-1:0] ACC_NEG = -ACC_POS;
    localparam logic signed [CMD_W-1:0] CMD_POS = CMD_W'(PWM_LIMIT);
    localparam logic signed [CMD_W-1:0] CMD_NEG = -CMD_POS;
    localparam logic signed [INTEG_W-1:0] INT_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INT_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // Configuration registers
    logic [DUTY_W-1:0]         pwm_period_reg;
    logic [15:0]               gain_p_reg;
    logic [15:0]               gain_i_reg;
    logic [15:0]               gain_d_reg;
    logic signed [INTEG_W-1:0] int_high_reg;
    logic signed [INTEG_W-1:0] int_low_reg;

    // Controller state
    mode_t                     mode_reg;
    logic signed [CMD_W-1:0]   held_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [CHG_W-1:0]   change_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] prev_drive_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [SEG_W-1:0]          seg_reg;
    logic                      phase_reg;

    // Working registers of one item
    logic signed [CUR_W-1:0]   meas_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic                      zero_duty_reg;
    logic                      shift_reg;
    logic                      res_dir_reg;
    logic signed [REF_W-1:0]   res_ref_reg;
    logic signed [CUR_W-1:0]   res_echo_reg;
    logic [SAMPLE_W-1:0]       res_idx_reg;
    logic                      res_sval_reg;

    // Output stage
    logic                      m_valid_reg;
    logic [DUTY_W-1:0]         m_duty_reg;
    logic                      m_dir_reg;
    logic signed [REF_W-1:0]   m_ref_reg;
    logic signed [CUR_W-1:0]   m_echo_reg;
    logic [SAMPLE_W-1:0]       m_idx_reg;
    logic                      m_sval_reg;
    logic [1:0]                m_mode_reg;

    ctl_t                      ctl;
    path_t                     path;
    logic                      out_free;
    logic                      test_done;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [CMD_W-1:0]   cmd_sat;
    logic [CMD_W-1:0]          cmd_abs;
    logic signed [ERR_W-1:0]   ref_now;
    logic signed [ERR_W-1:0]   err_now;
    logic signed [INTEG_W-1:0] int_clamped;
    logic signed [PROD_W-1:0]  d_bias;
    logic signed [PROD_W-1:0]  d_shift;
    logic signed [ACC_W-1:0]   drv_sum;
    logic signed [DRIVE_W-1:0] drv_clamp;
    logic [MAG_W-1:0]          drv_abs;
    logic signed [CHG_W-1:0]   change_next;
    logic signed [INTEG_W:0]   int_sum;
    logic signed [INTEG_W-1:0] integral_next;
    logic [RECIP_IN_W-1:0]     recip_in;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign test_done = (count_reg >= CNT_END);

    // Classify the item waiting at the input
    always_comb begin
        if (s_operation == OP_SET) begin
            path = PATH_QUICK;
        end else if (mode_reg == MODE_PWM) begin
            path = PATH_PWM;
        end else if (mode_reg == MODE_TEST && !test_done) begin
            path = PATH_TEST;
        end else begin
            path = PATH_QUICK;
        end
    end

    mcpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .path     (path),
        .out_free (out_free),
        .s_ready  (s_ready),
        .ctl      (ctl)
    );

    // Saturate the held PWM command and take its magnitude
    always_comb begin
        if (held_reg > CMD_POS) begin
            cmd_sat = CMD_POS;
        end else if (held_reg < CMD_NEG) begin
            cmd_sat = CMD_NEG;
        end else begin
            cmd_sat = held_reg;
        end
        cmd_abs = cmd_sat[CMD_W-1] ? CMD_W'(-cmd_sat) : CMD_W'(cmd_sat);
    end

    // Reference, error and integral clamp
    always_comb begin
        ref_now = phase_reg ? -AMP : AMP;
        err_now = ref_now - ERR_W'(meas_reg);
        if (integral_reg > int_high_reg) begin
            int_clamped = int_high_reg;
        end else if (integral_reg < int_low_reg) begin
            int_clamped = int_low_reg;
        end else begin
            int_clamped = integral_reg;
        end
    end

    // Drive update: subtract the truncated D term, clamp, derive the rest
    always_comb begin
        d_bias  = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        d_shift = d_bias >>> 8;
        drv_sum = acc_reg - $signed(d_shift[ACC_W-1:0]);
        if (drv_sum > ACC_POS) begin
            drv_clamp = DRIVE_W'(ACC_POS);
        end else if (drv_sum < ACC_NEG) begin
            drv_clamp = DRIVE_W'(ACC_NEG);
        end else begin
            drv_clamp = drv_sum[DRIVE_W-1:0];
        end
        drv_abs     = drv_clamp[DRIVE_W-1] ? MAG_W'(-drv_clamp) : MAG_W'(drv_clamp);
        change_next = CHG_W'(drv_clamp) - CHG_W'(prev_drive_reg);
        int_sum     = (INTEG_W+1)'(integral_reg) + (INTEG_W+1)'(err_reg);
        if (int_sum[INTEG_W] != int_sum[INTEG_W-1]) begin
            integral_next = int_sum[INTEG_W] ? INT_MIN : INT_MAX;
        end else begin
            integral_next = int_sum[INTEG_W-1:0];
        end
    end

    // Multiplier operands
    always_comb begin
        recip_in = shift_reg ? prod[RECIP_IN_W+7:8] : prod[RECIP_IN_W-1:0];
        mul_a    = '0;
        mul_b    = '0;
        case (ctl.mul_sel)
            MS_P: begin
                mul_a = MUL_W'(gain_p_reg);
                mul_b = MUL_W'(err_reg);
            end
            MS_I: begin
                mul_a = MUL_W'(gain_i_reg);
                mul_b = MUL_W'(integral_reg);
            end
            MS_D: begin
                mul_a = MUL_W'(gain_d_reg);
                mul_b = MUL_W'(change_reg);
            end
            MS_DUTY: begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(pwm_period_reg);
            end
            MS_RECIP: begin
                mul_a = MUL_W'(recip_in);
                mul_b = MUL_W'(RECIP_M);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    mcpi_mul u_mul (
        .aclk (aclk),
        .en   (ctl.mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg <= 16'd3999;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            int_high_reg   <= INT_MAX;
            int_low_reg    <= INT_MIN;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PWM_PERIOD:    pwm_period_reg <= cfg_data[DUTY_W-1:0];
                REG_GAIN_P:        gain_p_reg     <= cfg_data[15:0];
                REG_GAIN_I:        gain_i_reg     <= cfg_data[15:0];
                REG_GAIN_D:        gain_d_reg     <= cfg_data[15:0];
                REG_INTEGRAL_HIGH: int_high_reg   <= cfg_data[INTEG_W-1:0];
                REG_INTEGRAL_LOW:  int_low_reg    <= cfg_data[INTEG_W-1:0];
                default: ;
            endcase
        end
    end

    // Mode and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            held_reg       <= '0;
            integral_reg   <= '0;
            change_reg     <= '0;
            drive_reg      <= '0;
            prev_drive_reg <= '0;
            count_reg      <= '0;
            seg_reg        <= '0;
            phase_reg      <= 1'b0;
        end else begin
            if (ctl.load) begin
                if (s_operation == OP_SET) begin
                    case (s_new_mode)
                        MODE_IDLE: mode_reg <= MODE_IDLE;
                        MODE_PWM: begin
                            held_reg <= s_duty_command;
                            mode_reg <= MODE_PWM;
                        end
                        MODE_TEST: begin
                            integral_reg   <= '0;
                            change_reg     <= '0;
                            drive_reg      <= '0;
                            prev_drive_reg <= '0;
                            count_reg      <= '0;
                            seg_reg        <= '0;
                            phase_reg      <= 1'b0;
                            mode_reg       <= MODE_TEST;
                        end
                        default: ;
                    endcase
                end else if (mode_reg == MODE_TEST && test_done) begin
                    mode_reg <= MODE_IDLE;
                end
            end
            // clamp the integral before it feeds the I product
            if (ctl.err_step) begin
                integral_reg <= int_clamped;
            end
            // commit the new drive and advance the test sequence
            if (ctl.sum_step) begin
                drive_reg      <= drv_clamp;
                prev_drive_reg <= drv_clamp;
                change_reg     <= change_next;
                integral_reg   <= integral_next;
                count_reg      <= count_reg + 1'b1;
                if (seg_reg == SEG_LAST) begin
                    seg_reg   <= '0;
                    phase_reg <= !phase_reg;
                end else begin
                    seg_reg <= seg_reg + 1'b1;
                end
            end
        end
    end

    // Working registers of the item in flight
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            meas_reg      <= s_measured_current;
            zero_duty_reg <= (path == PATH_QUICK);
            shift_reg     <= (path == PATH_TEST);
            res_dir_reg   <= (path == PATH_PWM) ? !cmd_sat[CMD_W-1] : 1'b1;
            res_ref_reg   <= '0;
            res_echo_reg  <= '0;
            res_idx_reg   <= '0;
            res_sval_reg  <= 1'b0;
            if (path == PATH_PWM) begin
                mag_reg     <= MAG_W'(cmd_abs);
            end
        end
        if (ctl.err_step) begin
            err_reg      <= err_now;
            acc_reg      <= ACC_W'(drive_reg);
            res_ref_reg  <= REF_W'(ref_now);
            res_echo_reg <= meas_reg;
            res_idx_reg  <= SAMPLE_W'(count_reg);
            res_sval_reg <= 1'b1;
        end
        // accumulate the P and I products
        if (ctl.acc_add) begin
            acc_reg <= acc_reg + $signed(prod[ACC_W-1:0]);
        end
        if (ctl.sum_step) begin
            mag_reg     <= drv_abs;
            res_dir_reg <= !drv_clamp[DRIVE_W-1];
        end
    end

    // Output register: hold the item until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_step && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_step && out_free) begin
            m_duty_reg <= zero_duty_reg ? '0 : prod[RECIP_SHIFT +: DUTY_W];
            m_dir_reg  <= res_dir_reg;
            m_ref_reg  <= res_ref_reg;
            m_echo_reg <= res_echo_reg;
            m_idx_reg  <= res_idx_reg;
            m_sval_reg <= res_sval_reg;
            m_mode_reg <= mode_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_duty_value        = m_duty_reg;
    assign m_direction         = m_dir_reg;
    assign m_reference_current = m_ref_reg;
    assign m_current_echo      = m_echo_reg;
    assign m_sample_index      = m_idx_reg;
    assign m_sample_valid      = m_sval_reg;
    assign m_mode_now          = m_mode_reg;

`ifndef ASSERT_OFF
    // A result appears only from the sequencer's output step
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctl.out_step))
        else $error("result raised outside the output step");

    // Drive stays within +/-100 percent
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (drive_reg <= DRIVE_W'(DRIVE_FULL)) && (drive_reg >= -DRIVE_W'(DRIVE_FULL)))
        else $error("drive level out of range");

    // Test sample count never passes the end of the test
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_END)
        else $error("test sample count overran");

    // A logged sample is only reported while in test mode
    a_sample_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sample_valid) |-> (m_mode_now == MODE_TEST))
        else $error("sample reported outside test mode");
`endif

endmodule
